/* hw/rtl/quaternion_to_pitch_roll_top_assert.svh */
// Assertion macros used by the checker of the quaternion to pitch and roll block.
`ifndef QUATERNION_TO_PITCH_ROLL_TOP_ASSERT_SVH
`define QUATERNION_TO_PITCH_ROLL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define Q2PR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion_to_pitch_roll: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define Q2PR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion_to_pitch_roll: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define Q2PR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("quaternion_to_pitch_roll: reset check failed");

`endif

/* hw/rtl/q2pr_pkg.sv */
// Package with constants, angle table and rounding for the quaternion to pitch and roll block.
`timescale 1ns / 1ps

package q2pr_pkg;

   // Defaults for the top-level parameters.
   localparam int CORDIC_STAGES = 16;
   localparam int QUAT_WIDTH    = 16;

   // Datapath widths: rotation terms and CORDIC vectors, angle accumulator, angle output.
   localparam int DW = 40;
   localparam int ZW = 34;
   localparam int AW = 16;

   localparam logic signed [ZW-1:0] HALF_PI  = 34'sd1686629713;
   localparam logic [23:0]          INV_GAIN = 24'd10188014;
   localparam int                   PITCH_MAX = 12868;
   localparam int                   ROLL_MAX  = 25736;

   // Arctangent of 2^-idx in Q30 radians, truncated.
   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = 34'sh03243F6A8;
         1:  v = 34'sh01DAC6705;
         2:  v = 34'sh00FADBAFC;
         3:  v = 34'sh007F56EA6;
         4:  v = 34'sh003FEAB76;
         5:  v = 34'sh001FFD55B;
         6:  v = 34'sh000FFFAAA;
         7:  v = 34'sh0007FFF55;
         8:  v = 34'sh0003FFFEA;
         9:  v = 34'sh0001FFFFD;
         10: v = 34'sh0000FFFFF;
         11: v = 34'sh00007FFFF;
         12: v = 34'sh00003FFFF;
         13: v = 34'sh00001FFFF;
         14: v = 34'sh00000FFFF;
         15: v = 34'sh000007FFF;
         16: v = 34'sh000003FFF;
         17: v = 34'sh000001FFF;
         18: v = 34'sh000000FFF;
         19: v = 34'sh0000007FF;
         20: v = 34'sh0000003FF;
         21: v = 34'sh0000001FF;
         22: v = 34'sh0000000FF;
         23: v = 34'sh00000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q30 angle to Q13 with round half up, then clamped to plus or minus lim.
   function automatic logic signed [AW-1:0] round_clamp(input logic signed [ZW-1:0] z,
                                                         input int lim);
      logic signed [ZW:0]   sum;
      logic signed [ZW-17:0] r;
      logic signed [ZW-17:0] hi;
      logic signed [ZW-17:0] lo;
      logic signed [AW-1:0] res;
      sum = {z[ZW-1], z} + (ZW+1)'(65536);
      r   = sum[ZW:17];
      hi  = (ZW-16)'(lim);
      lo  = -hi;
      if (r > hi) begin
         res = hi[AW-1:0];
      end else if (r < lo) begin
         res = lo[AW-1:0];
      end else begin
         res = r[AW-1:0];
      end
      return res;
   endfunction

endpackage

/* hw/rtl/q2pr_terms.sv */
// Two-stage pipeline that forms the rotation terms r31, r32 and r33 from a Q1.14 quaternion.
`timescale 1ns / 1ps

module q2pr_terms (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [15:0]               w,
   input  logic signed [15:0]               x,
   input  logic signed [15:0]               y,
   input  logic signed [15:0]               z,
   output logic                             out_valid,
   output logic signed [q2pr_pkg::DW-1:0]   r31,
   output logic signed [q2pr_pkg::DW-1:0]   r32,
   output logic signed [q2pr_pkg::DW-1:0]   r33
);

   localparam int DW = q2pr_pkg::DW;

   logic                 v1_ff, v2_ff;
   logic signed [31:0]   xz_ff, wy_ff, wx_ff, yz_ff, ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [q2pr_pkg::DW-1:0] r31_ff, r32_ff, r33_ff;

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // Stage one: the eight products.
   always_ff @(posedge clock) begin
      if (en) begin
         xz_ff <= x * z;
         wy_ff <= w * y;
         wx_ff <= w * x;
         yz_ff <= y * z;
         ww_ff <= w * w;
         xx_ff <= x * x;
         yy_ff <= y * y;
         zz_ff <= z * z;
      end
   end

   // Stage two: sums, with the factor of two as a shift.
   always_ff @(posedge clock) begin
      if (en) begin
         r31_ff <= (DW'(xz_ff) - DW'(wy_ff)) <<< 1;
         r32_ff <= (DW'(wx_ff) + DW'(yz_ff)) <<< 1;
         r33_ff <= DW'(ww_ff) - DW'(xx_ff) - DW'(yy_ff) + DW'(zz_ff);
      end
   end

   assign out_valid = v2_ff;
   assign r31 = r31_ff;
   assign r32 = r32_ff;
   assign r33 = r33_ff;

endmodule

/* hw/rtl/q2pr_cell.sv */
// One CORDIC vectoring iteration as a pipeline cell with a fixed shift.
`timescale 1ns / 1ps

module q2pr_cell #(
   parameter int STAGE = 0,
   parameter int SW    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [q2pr_pkg::DW-1:0] in_a,
   input  logic signed [q2pr_pkg::DW-1:0] in_b,
   input  logic signed [q2pr_pkg::ZW-1:0] in_z,
   input  logic                           in_zero,
   input  logic [SW-1:0]                  in_side,
   output logic                           out_valid,
   output logic signed [q2pr_pkg::DW-1:0] out_a,
   output logic signed [q2pr_pkg::DW-1:0] out_b,
   output logic signed [q2pr_pkg::ZW-1:0] out_z,
   output logic                           out_zero,
   output logic [SW-1:0]                  out_side
);

   localparam logic signed [q2pr_pkg::ZW-1:0] ATAN = q2pr_pkg::atan_q30(STAGE);

   logic                           valid_ff;
   logic signed [q2pr_pkg::DW-1:0] a_ff, b_ff, a_in, b_in;
   logic signed [q2pr_pkg::ZW-1:0] z_ff, z_in;
   logic                           zero_ff;
   logic [SW-1:0]                  side_ff;

   // Rotate toward the positive x axis by the sign of b.
   always_comb begin
      if (!in_b[q2pr_pkg::DW-1]) begin
         a_in = in_a + (in_b >>> STAGE);
         b_in = in_b - (in_a >>> STAGE);
         z_in = in_z + ATAN;
      end else begin
         a_in = in_a - (in_b >>> STAGE);
         b_in = in_b + (in_a >>> STAGE);
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         z_ff    <= z_in;
         zero_ff <= in_zero;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_z     = z_ff;
   assign out_zero  = zero_ff;
   assign out_side  = side_ff;

endmodule

/* hw/rtl/q2pr_vector.sv */
// CORDIC vectoring atan2: a pre-rotation stage followed by a chain of iteration cells.
`timescale 1ns / 1ps

module q2pr_vector #(
   parameter int STAGES = q2pr_pkg::CORDIC_STAGES,
   parameter int SW     = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [q2pr_pkg::DW-1:0] in_a,
   input  logic signed [q2pr_pkg::DW-1:0] in_b,
   input  logic [SW-1:0]                  in_side,
   output logic                           out_valid,
   output logic signed [q2pr_pkg::DW-1:0] out_mag,
   output logic signed [q2pr_pkg::ZW-1:0] out_z,
   output logic                           out_zero,
   output logic [SW-1:0]                  out_side
);

   localparam int DW = q2pr_pkg::DW;
   localparam int ZW = q2pr_pkg::ZW;

   logic                 valid_ff;
   logic signed [DW-1:0] a_ff, b_ff, a_in, b_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 zero_ff;
   logic [SW-1:0]        side_ff;

   // Pre-rotation by a quarter turn when the vector lies in the left half plane.
   always_comb begin
      if (in_a[DW-1]) begin
         if (!in_b[DW-1]) begin
            a_in = in_b;
            b_in = -in_a;
            z_in = q2pr_pkg::HALF_PI;
         end else begin
            a_in = -in_b;
            b_in = in_a;
            z_in = -q2pr_pkg::HALF_PI;
         end
      end else begin
         a_in = in_a;
         b_in = in_b;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         z_ff    <= z_in;
         zero_ff <= (in_a == '0) && (in_b == '0);
         side_ff <= in_side;
      end
   end

   // Links between cells; entry 0 is the pre-rotation stage.
   logic                 ch_valid [STAGES+1];
   logic signed [DW-1:0] ch_a     [STAGES+1];
   logic signed [DW-1:0] ch_b     [STAGES+1];
   logic signed [ZW-1:0] ch_z     [STAGES+1];
   logic                 ch_zero  [STAGES+1];
   logic [SW-1:0]        ch_side  [STAGES+1];

   assign ch_valid[0] = valid_ff;
   assign ch_a[0]     = a_ff;
   assign ch_b[0]     = b_ff;
   assign ch_z[0]     = z_ff;
   assign ch_zero[0]  = zero_ff;
   assign ch_side[0]  = side_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      q2pr_cell #(.STAGE(i), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (ch_valid[i]),
         .in_a      (ch_a[i]),
         .in_b      (ch_b[i]),
         .in_z      (ch_z[i]),
         .in_zero   (ch_zero[i]),
         .in_side   (ch_side[i]),
         .out_valid (ch_valid[i+1]),
         .out_a     (ch_a[i+1]),
         .out_b     (ch_b[i+1]),
         .out_z     (ch_z[i+1]),
         .out_zero  (ch_zero[i+1]),
         .out_side  (ch_side[i+1])
      );
   end

   assign out_valid = ch_valid[STAGES];
   assign out_mag   = ch_a[STAGES];
   assign out_z     = ch_z[STAGES];
   assign out_zero  = ch_zero[STAGES];
   assign out_side  = ch_side[STAGES];

endmodule

/* hw/rtl/quaternion_to_pitch_roll_top.sv */
// Top level: quaternion to pitch and roll angles through two pipelined CORDIC chains.
//
//   Group  Dir  Payload (low bit first)                        Handshake
//   req_   in   quat_w, quat_x, quat_y, quat_z (QUAT_WIDTH)    tvalid / tready
//   rsp_   out  pitch_angle (15), roll_angle (16), zero pad    tvalid / tready
//
// One transaction per cycle is accepted when the output is free or being taken.
// Stages in order: two product/sum stages, the roll chain (pre-rotation plus one cell
// per iteration), two gain stages, the pitch chain, and the output register.
// The whole pipeline holds while a result waits and rsp_tready is low.
// Reset is synchronous and clears every valid bit; no clearing pass is needed.
`timescale 1ns / 1ps

module quaternion_to_pitch_roll_top #(
   parameter int CORDIC_STAGES = q2pr_pkg::CORDIC_STAGES,
   parameter int QUAT_WIDTH    = q2pr_pkg::QUAT_WIDTH,
   localparam int REQ_W        = ((4 * QUAT_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // quat_w, quat_x, quat_y, quat_z, each QUAT_WIDTH bits, then zero padding
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pitch_angle [14:0], roll_angle [30:15], zero [31]
   output logic [31:0]      rsp_tdata
);

   localparam int DW = q2pr_pkg::DW;
   localparam int ZW = q2pr_pkg::ZW;
   localparam int AW = q2pr_pkg::AW;

   logic en;
   logic rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   // Pipeline moves whenever the output register is empty or being drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Bring each component to Q1.14.
   logic signed [15:0] q14 [4];
   for (genvar k = 0; k < 4; k++) begin : g_q14
      if (QUAT_WIDTH >= 16) begin : g_down
         assign q14[k] = req_tdata[k*QUAT_WIDTH + QUAT_WIDTH - 1 -: 16];
      end else begin : g_up
         assign q14[k] = {req_tdata[k*QUAT_WIDTH +: QUAT_WIDTH], {(16-QUAT_WIDTH){1'b0}}};
      end
   end

   logic                 t_valid;
   logic signed [DW-1:0] r31, r32, r33;

   q2pr_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .w         (q14[0]),
      .x         (q14[1]),
      .y         (q14[2]),
      .z         (q14[3]),
      .out_valid (t_valid),
      .r31       (r31),
      .r32       (r32),
      .r33       (r33)
   );

   // Roll chain: atan2(r32, r33); -r31 rides along for the pitch step.
   logic                 rv_valid, rv_zero;
   logic signed [DW-1:0] rv_mag;
   logic signed [ZW-1:0] rv_z;
   logic [DW-1:0]        rv_side;

   q2pr_vector #(.STAGES(CORDIC_STAGES), .SW(DW)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t_valid),
      .in_a      (r33),
      .in_b      (r32),
      .in_side   (-r31),
      .out_valid (rv_valid),
      .out_mag   (rv_mag),
      .out_z     (rv_z),
      .out_zero  (rv_zero),
      .out_side  (rv_side)
   );

   // Gain stage one: split magnitude times 1/K, and the final roll angle.
   logic                 g1_valid_ff, g2_valid_ff;
   logic [40:0]          p_lo_ff, p_hi_ff;
   logic [DW-1:0]        nr31_g1_ff, nr31_g2_ff;
   logic [AW-1:0]        roll_g1_ff, roll_g2_ff;
   logic signed [DW-1:0] hyp_ff;
   logic [63:0]          hyp_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
      end else if (en) begin
         g1_valid_ff <= rv_valid;
         g2_valid_ff <= g1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_lo_ff    <= 41'(rv_mag[16:0]) * 41'(q2pr_pkg::INV_GAIN);
         p_hi_ff    <= 41'(rv_mag[33:17]) * 41'(q2pr_pkg::INV_GAIN);
         nr31_g1_ff <= rv_side;
         roll_g1_ff <= rv_zero ? '0 : q2pr_pkg::round_clamp(rv_z, q2pr_pkg::ROLL_MAX);
      end
   end

   // Gain stage two: recombine and round to the hypotenuse.
   assign hyp_sum = ({23'd0, p_hi_ff} << 17) + {23'd0, p_lo_ff} + 64'd8388608;

   always_ff @(posedge clock) begin
      if (en) begin
         hyp_ff     <= hyp_sum[24 +: DW];
         nr31_g2_ff <= nr31_g1_ff;
         roll_g2_ff <= roll_g1_ff;
      end
   end

   // Pitch chain: atan2(-r31, hyp); the roll angle rides along.
   logic                 pv_valid, pv_zero;
   logic signed [DW-1:0] pv_mag;
   logic signed [ZW-1:0] pv_z;
   logic [AW-1:0]        pv_side;
   logic signed [AW-1:0] pitch_full;

   q2pr_vector #(.STAGES(CORDIC_STAGES), .SW(AW)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g2_valid_ff),
      .in_a      (hyp_ff),
      .in_b      (nr31_g2_ff),
      .in_side   (roll_g2_ff),
      .out_valid (pv_valid),
      .out_mag   (pv_mag),
      .out_z     (pv_z),
      .out_zero  (pv_zero),
      .out_side  (pv_side)
   );

   // The pitch magnitude only guards the angle; its sign bit, always clear, zeroes it if set.
   assign pitch_full = (pv_zero || pv_mag[DW-1]) ? '0
                       : q2pr_pkg::round_clamp(pv_z, q2pr_pkg::PITCH_MAX);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= pv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {1'b0, pv_side, pitch_full[14:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/q2pr_checker.sv */
// Port-level checker for the quaternion to pitch and roll block, bound to the top level.
`timescale 1ns / 1ps
`include "quaternion_to_pitch_roll_top_assert.svh"

module q2pr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [31:0]      rsp_tdata
);

   logic pitch_ok, roll_ok;

   assign pitch_ok = ($signed(rsp_tdata[14:0]) <= 15'sd12868)
                     && ($signed(rsp_tdata[14:0]) >= -15'sd12868);
   assign roll_ok  = ($signed(rsp_tdata[30:15]) <= 16'sd25736)
                     && ($signed(rsp_tdata[30:15]) >= -16'sd25736)
                     && !rsp_tdata[31];

   // A held result stays offered.
   `Q2PR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // The input side never stalls while the output register is empty.
   `Q2PR_ASSERT_IMPLY(a_req_free, clock, reset, !rsp_tvalid, req_tready)
   // Angles stay inside their clamps and the pad bit is zero.
   `Q2PR_ASSERT_IMPLY(a_range, clock, reset, rsp_tvalid, pitch_ok && roll_ok)
   // No result can appear right after reset.
   `Q2PR_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind quaternion_to_pitch_roll_top q2pr_checker u_q2pr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
